// ----- src/sm3_pkg.sv -----
// ----------------------------------------------------------------------------
// sm3_pkg
// Shared types, constants and helper functions for the SM3 hash engine.
// ----------------------------------------------------------------------------
`default_nettype none

package sm3_pkg;

   // Bit width of the message byte counter
   localparam int unsigned BC_W = 61;

   // Depth of the word queue between front and back
   localparam int unsigned QDEPTH = 4;
   localparam int unsigned QPTR_W = $clog2(QDEPTH);

   // Initial vector, word 0 in the top bits
   localparam logic [255:0] SM3_IV = {
      32'h7380166F, 32'h4914B2B9, 32'h172442D7, 32'hDA8A0600,
      32'hA96F30BC, 32'h163138AA, 32'hE38DEE4D, 32'hB0FB0E4E
   };

   // Round constants
   localparam logic [31:0] T_LO = 32'h79CC4519;
   localparam logic [31:0] T_HI = 32'h7A879D8A;

   // Padding marker byte in the top byte lane
   localparam logic [31:0] PAD_MARK = 32'h8000_0000;

   // Word index in the block where the length field starts
   localparam logic [3:0] LEN_WORD = 4'd14;

   // Entry of the word queue: one block word plus end-of-message flag
   typedef struct packed {
      logic [31:0] word;
      logic        fin;
   } qent_type;

   function automatic logic [31:0] rol(input logic [31:0] v, input int unsigned n);
      logic [31:0] r;
      if (n == 0) begin
         r = v;
      end else begin
         r = (v << n) | (v >> (32 - n));
      end
      return r;
   endfunction

   function automatic logic [31:0] perm0(input logic [31:0] x);
      return x ^ rol(x, 9) ^ rol(x, 17);
   endfunction

   function automatic logic [31:0] perm1(input logic [31:0] x);
      return x ^ rol(x, 15) ^ rol(x, 23);
   endfunction

   // Round constant used from round 16 on, pre-rotated by 16
   localparam logic [31:0] T_HI_R16 = rol(T_HI, 16);

   function automatic logic [31:0] iv_word(input logic [2:0] idx);
      return SM3_IV[255 - 32 * idx -: 32];
   endfunction

endpackage

`default_nettype wire

// ----- src/sm3_if.sv -----
// ----------------------------------------------------------------------------
// sm3_if
// Valid/ready channel interfaces for message input and digest output.
// ----------------------------------------------------------------------------
`default_nettype none

interface sm3_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] message_word;
   logic [2:0]  valid_bytes;
   logic        end_of_message;

   modport source (output valid, message_word, valid_bytes, end_of_message,
                   input ready);
   modport sink   (input valid, message_word, valid_bytes, end_of_message,
                   output ready);
endinterface

interface sm3_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic [2:0]  word_index;
   logic        last_word;

   modport source (output valid, digest_word, word_index, last_word,
                   input ready);
   modport sink   (input valid, digest_word, word_index, last_word,
                   output ready);
endinterface

`default_nettype wire

// ----- src/sm3_front.sv -----
// ----------------------------------------------------------------------------
// sm3_front
// Byte gatherer and padder: packs message bytes into block words, then adds
// the marker, zero fill and bit length at end of message.
// ----------------------------------------------------------------------------
`default_nettype none

module sm3_front (
   input  wire logic              clock,
   input  wire logic              reset,
   sm3_req_if.sink                req,
   output sm3_pkg::qent_type      q_din,
   output logic                   q_push,
   input  wire logic              q_full
);
   import sm3_pkg::*;

   typedef enum logic [4:0] {
      F_IN    = 5'b00001,
      F_FIRST = 5'b00010,
      F_ZERO  = 5'b00100,
      F_LENHI = 5'b01000,
      F_LENLO = 5'b10000
   } fstate_type;

   fstate_type       state_ff, state_in;
   logic [31:0]      pw_ff, pw_in;
   logic [1:0]       pcnt_ff, pcnt_in;
   logic [BC_W-1:0]  bc_ff, bc_in;
   logic [3:0]       wi_ff, wi_in;

   logic [2:0]       nbytes;
   logic [31:0]      mask;
   logic [63:0]      comb;
   logic [2:0]       total;
   logic             xfer;

   // Clamp the byte count and mask off unused lanes
   always_comb begin
      nbytes = (req.valid_bytes > 3'd4) ? 3'd4 : req.valid_bytes;
      case (nbytes)
         3'd0:    mask = 32'h0000_0000;
         3'd1:    mask = 32'hFF00_0000;
         3'd2:    mask = 32'hFFFF_0000;
         3'd3:    mask = 32'hFFFF_FF00;
         default: mask = 32'hFFFF_FFFF;
      endcase
      comb  = {pw_ff, 32'h0} | ({req.message_word & mask, 32'h0} >> {pcnt_ff, 3'b000});
      total = {1'b0, pcnt_ff} + nbytes;
   end

   assign req.ready = (state_ff == F_IN) && !q_full;
   assign xfer      = req.valid && req.ready;

   // Sequencer
   always_comb begin
      state_in = state_ff;
      pw_in    = pw_ff;
      pcnt_in  = pcnt_ff;
      bc_in    = bc_ff;
      wi_in    = wi_ff;
      q_push   = 1'b0;
      q_din    = '{word: 32'h0, fin: 1'b0};
      unique case (state_ff)
         F_IN: begin
            if (xfer) begin
               bc_in   = bc_ff + BC_W'(nbytes);
               pcnt_in = total[1:0];
               if (total[2]) begin
                  q_push  = 1'b1;
                  q_din   = '{word: comb[63:32], fin: 1'b0};
                  pw_in   = comb[31:0];
                  wi_in   = wi_ff + 4'd1;
               end else begin
                  pw_in = comb[63:32];
               end
               if (req.end_of_message) begin
                  state_in = F_FIRST;
               end
            end
         end
         F_FIRST: begin
            if (!q_full) begin
               q_push   = 1'b1;
               q_din    = '{word: pw_ff | (PAD_MARK >> {pcnt_ff, 3'b000}), fin: 1'b0};
               wi_in    = wi_ff + 4'd1;
               state_in = (wi_in == LEN_WORD) ? F_LENHI : F_ZERO;
            end
         end
         F_ZERO: begin
            if (!q_full) begin
               q_push   = 1'b1;
               wi_in    = wi_ff + 4'd1;
               state_in = (wi_in == LEN_WORD) ? F_LENHI : F_ZERO;
            end
         end
         F_LENHI: begin
            if (!q_full) begin
               q_push   = 1'b1;
               q_din    = '{word: bc_ff[60:29], fin: 1'b0};
               wi_in    = wi_ff + 4'd1;
               state_in = F_LENLO;
            end
         end
         F_LENLO: begin
            if (!q_full) begin
               q_push   = 1'b1;
               q_din    = '{word: {bc_ff[28:0], 3'b000}, fin: 1'b1};
               // start afresh for the next message
               wi_in    = 4'd0;
               bc_in    = '0;
               pw_in    = 32'h0;
               pcnt_in  = 2'd0;
               state_in = F_IN;
            end
         end
         default: state_in = F_IN;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IN;
         pw_ff    <= 32'h0;
         pcnt_ff  <= 2'd0;
         bc_ff    <= '0;
         wi_ff    <= 4'd0;
      end else begin
         state_ff <= state_in;
         pw_ff    <= pw_in;
         pcnt_ff  <= pcnt_in;
         bc_ff    <= bc_in;
         wi_ff    <= wi_in;
      end
   end

endmodule

`default_nettype wire

// ----- src/sm3_fifo.sv -----
// ----------------------------------------------------------------------------
// sm3_fifo
// Short word queue between the padder and the compression core.
// ----------------------------------------------------------------------------
`default_nettype none

module sm3_fifo (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire sm3_pkg::qent_type din,
   output logic                   full,
   input  wire logic              pop,
   output sm3_pkg::qent_type      dout,
   output logic                   empty
);
   import sm3_pkg::*;

   qent_type            mem_ff [QDEPTH];
   logic [QPTR_W-1:0]   wr_ff, wr_in;
   logic [QPTR_W-1:0]   rd_ff, rd_in;
   logic [QPTR_W:0]     cnt_ff, cnt_in;
   logic                do_push, do_pop;

   assign full    = (cnt_ff == (QPTR_W+1)'(QDEPTH));
   assign empty   = (cnt_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign dout    = mem_ff[rd_ff];

   // Pointer and fill count update
   always_comb begin
      wr_in  = do_push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = do_pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + (QPTR_W+1)'(do_push) - (QPTR_W+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= din;
      end
   end

endmodule

`default_nettype wire

// ----- src/sm3_back.sv -----
// ----------------------------------------------------------------------------
// sm3_back
// Compression core: loads 16 block words, runs 64 rounds with on-the-fly
// message expansion, folds into the chaining value and emits the digest.
// ----------------------------------------------------------------------------
`default_nettype none

module sm3_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire sm3_pkg::qent_type q_dout,
   input  wire logic              q_empty,
   output logic                   q_pop,
   sm3_rsp_if.source              rsp
);
   import sm3_pkg::*;

   typedef enum logic [2:0] {
      B_LOAD  = 3'b001,
      B_ROUND = 3'b010,
      B_OUT   = 3'b100
   } bstate_type;

   bstate_type   state_ff, state_in;
   logic [31:0]  win_ff [16];
   logic [31:0]  win_in [16];
   logic [31:0]  v_ff [8];
   logic [31:0]  v_in [8];
   logic [31:0]  cv_ff [8];
   logic [31:0]  cv_in [8];
   logic [3:0]   cnt_ff, cnt_in;
   logic [5:0]   rnd_ff, rnd_in;
   logic [2:0]   oidx_ff, oidx_in;
   logic         fin_ff, fin_in;
   logic [31:0]  tj_ff, tj_in;
   logic         ov_ff, ov_in;
   logic [31:0]  od_ff, od_in;
   logic [2:0]   oi_ff, oi_in;
   logic         ol_ff, ol_in;

   logic [31:0]  a12, ss1, ss2, ffv, ggv, tt1, tt2, wnew;
   logic [31:0]  vr [8];
   logic         early;

   assign rsp.valid       = ov_ff;
   assign rsp.digest_word = od_ff;
   assign rsp.word_index  = oi_ff;
   assign rsp.last_word   = ol_ff;

   // One compression round and one expansion step
   always_comb begin
      early = (rnd_ff[5:4] == 2'b00);
      a12   = rol(v_ff[0], 12);
      ss1   = rol(a12 + v_ff[4] + tj_ff, 7);
      ss2   = ss1 ^ a12;
      ffv   = early ? (v_ff[0] ^ v_ff[1] ^ v_ff[2])
                    : ((v_ff[0] & v_ff[1]) | (v_ff[0] & v_ff[2]) | (v_ff[1] & v_ff[2]));
      ggv   = early ? (v_ff[4] ^ v_ff[5] ^ v_ff[6])
                    : ((v_ff[4] & v_ff[5]) | (~v_ff[4] & v_ff[6]));
      tt1   = ffv + v_ff[3] + ss2 + (win_ff[0] ^ win_ff[4]);
      tt2   = ggv + v_ff[7] + ss1 + win_ff[0];
      vr[0] = tt1;
      vr[1] = v_ff[0];
      vr[2] = rol(v_ff[1], 9);
      vr[3] = v_ff[2];
      vr[4] = perm0(tt2);
      vr[5] = v_ff[4];
      vr[6] = rol(v_ff[5], 19);
      vr[7] = v_ff[6];
      wnew  = perm1(win_ff[0] ^ win_ff[7] ^ rol(win_ff[13], 15))
              ^ rol(win_ff[3], 7) ^ win_ff[10];
   end

   // Sequencer
   always_comb begin
      state_in = state_ff;
      win_in   = win_ff;
      v_in     = v_ff;
      cv_in    = cv_ff;
      cnt_in   = cnt_ff;
      rnd_in   = rnd_ff;
      oidx_in  = oidx_ff;
      fin_in   = fin_ff;
      tj_in    = tj_ff;
      q_pop    = 1'b0;
      ov_in    = ov_ff && !rsp.ready;
      od_in    = od_ff;
      oi_in    = oi_ff;
      ol_in    = ol_ff;
      unique case (state_ff)
         B_LOAD: begin
            if (!q_empty) begin
               q_pop = 1'b1;
               for (int i = 0; i < 15; i++) begin
                  win_in[i] = win_ff[i+1];
               end
               win_in[15] = q_dout.word;
               fin_in     = q_dout.fin;
               cnt_in     = cnt_ff + 4'd1;
               if (cnt_ff == 4'd15) begin
                  v_in     = cv_ff;
                  rnd_in   = 6'd0;
                  tj_in    = T_LO;
                  state_in = B_ROUND;
               end
            end
         end
         B_ROUND: begin
            for (int i = 0; i < 15; i++) begin
               win_in[i] = win_ff[i+1];
            end
            win_in[15] = wnew;
            v_in       = vr;
            rnd_in     = rnd_ff + 6'd1;
            tj_in      = (rnd_ff == 6'd15) ? T_HI_R16 : rol(tj_ff, 1);
            if (rnd_ff == 6'd63) begin
               for (int i = 0; i < 8; i++) begin
                  cv_in[i] = cv_ff[i] ^ vr[i];
               end
               oidx_in  = 3'd0;
               state_in = fin_ff ? B_OUT : B_LOAD;
            end
         end
         B_OUT: begin
            if (!ov_ff || rsp.ready) begin
               ov_in   = 1'b1;
               od_in   = cv_ff[oidx_ff];
               oi_in   = oidx_ff;
               ol_in   = (oidx_ff == 3'd7);
               oidx_in = oidx_ff + 3'd1;
               if (oidx_ff == 3'd7) begin
                  // last digest word registered for output: back to the initial vector
                  for (int i = 0; i < 8; i++) begin
                     cv_in[i] = iv_word(3'(i));
                  end
                  state_in = B_LOAD;
               end
            end
         end
         default: state_in = B_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_LOAD;
         cnt_ff   <= 4'd0;
         rnd_ff   <= 6'd0;
         oidx_ff  <= 3'd0;
         fin_ff   <= 1'b0;
         ov_ff    <= 1'b0;
         for (int i = 0; i < 8; i++) begin
            cv_ff[i] <= iv_word(3'(i));
         end
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         rnd_ff   <= rnd_in;
         oidx_ff  <= oidx_in;
         fin_ff   <= fin_in;
         ov_ff    <= ov_in;
         cv_ff    <= cv_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      win_ff <= win_in;
      v_ff   <= v_in;
      tj_ff  <= tj_in;
      od_ff  <= od_in;
      oi_ff  <= oi_in;
      ol_ff  <= ol_in;
   end

endmodule

`default_nettype wire

// ----- src/sm3_hash_engine.sv -----
// The core loads the sixteen words of a 64-byte block, then runs 64 rounds in
// the single round unit; it takes no new block words until the rounds finish,
// while the word queue holds up to four words from the padder. Eight digest
// words are output per message, after its last block.
// Reset (synchronous, active high) loads the initial vector, clears counts.
// ----------------------------------------------------------------------------
// sm3_hash_engine
// Streaming SM3 hash: padder front end, word queue, compression back end.
// ----------------------------------------------------------------------------
`default_nettype none

module sm3_hash_engine (
   input  wire logic  clock,
   input  wire logic  reset,
   sm3_req_if.sink    req,
   sm3_rsp_if.source  rsp
);
   import sm3_pkg::*;

   qent_type  q_din, q_dout;
   logic      q_push, q_full, q_pop, q_empty;

   // Byte gathering and padding
   sm3_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req    (req),
      .q_din  (q_din),
      .q_push (q_push),
      .q_full (q_full)
   );

   // Word queue
   sm3_fifo u_fifo (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .din   (q_din),
      .full  (q_full),
      .pop   (q_pop),
      .dout  (q_dout),
      .empty (q_empty)
   );

   // Compression and digest output
   sm3_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_dout  (q_dout),
      .q_empty (q_empty),
      .q_pop   (q_pop),
      .rsp     (rsp)
   );

endmodule

`default_nettype wire

// ----- src/sm3_checker.sv -----
// ----------------------------------------------------------------------------
// sm3_checker
// Port-level checks on the digest channel of the hash engine.
// ----------------------------------------------------------------------------
`default_nettype none

module sm3_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [31:0] rsp_digest_word,
   input wire logic [2:0]  rsp_word_index,
   input wire logic        rsp_last_word
);

   // Stalled digest word holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_digest_word)
                                  && $stable(rsp_word_index))
      else $error("digest word changed under stall");

   // Last flag marks exactly the eighth word
   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last_word == (rsp_word_index == 3'd7)))
      else $error("last flag does not match word index");

   // Digest words follow back to back in order
   a_seq: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_word |=>
         rsp_valid && (rsp_word_index == $past(rsp_word_index) + 3'd1))
      else $error("digest words out of sequence");

   // Nothing comes out right after reset
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("digest valid right after reset");

endmodule

bind sm3_hash_engine sm3_checker u_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp.valid),
   .rsp_ready       (rsp.ready),
   .rsp_digest_word (rsp.digest_word),
   .rsp_word_index  (rsp.word_index),
   .rsp_last_word   (rsp.last_word)
);

`default_nettype wire
